// ----- rtl/fbbl_pkg.sv -----
// Shared constants and helper function of the FFT band bar level block.
// No dependencies; imported by fft_band_bar_levels_top.
package fbbl_pkg;

    localparam int NUM_BANDS        = 20;
    localparam int FIRST_BAND_WIDTH = 3;

    localparam int BIN_W      = 16;
    localparam int BAND_W     = 5;
    localparam int LEVEL_W    = 5;
    localparam int GLYPH_W    = 5;
    localparam int SUM_W      = 21;
    localparam int DIV_W      = 12;
    localparam int TOTAL_W    = 7;
    localparam int PROD_W     = TOTAL_W + GLYPH_W;
    localparam int DIV_STEPS  = SUM_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int WIDTH_W    = BAND_W + 1;

    localparam int DIV_BASE   = 2048;
    localparam int DIV_STEP   = 90;
    localparam int TOTAL_MAX  = 110;
    localparam int SCALE_DIV  = 125;
    localparam int GLYPH_RESET = 6;
    localparam int DECIM_MASK_W = 2;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_DECIMATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT    = 1'b1;

    function automatic logic [DIV_W-1:0] band_divisor(input logic [BAND_W-1:0] band);
        int d;
        d = DIV_BASE - DIV_STEP * int'(band);
        if (d > 0)
            return DIV_W'(d);
        else
            return DIV_W'(1);
    endfunction

endpackage

// ----- rtl/fft_band_bar_levels_top.sv -----
// FFT band bar level block: band accumulation, shared bit-serial divider, frame emission.
// Depends on fbbl_pkg.
//
// Bins arrive one per item and are accepted one per cycle until a bin closes a band; that
// bin is followed by s_axis_tready low while the single bit-serial restoring divider runs
// twice (21 steps for the band sum, 21 for the level scaling) and the level is stored. A
// frame holds 250 bins. When a frame emits, input is also held while the 20 band items
// leave through the output register, one per cycle when m_axis_tready stays high.
module fft_band_bar_levels_top
    import fbbl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] bin_value
    input  logic [IN_USER_W-1:0]  s_axis_tuser,   // [0] first_bin, [1] refresh
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [4:0] band_number, [9:5] bar_level
    output logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_BAND,
        ST_SCALE,
        ST_DIV_LEVEL,
        ST_STORE,
        ST_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic                    decimate_reg, decimate_next;
    logic [GLYPH_W-1:0]      glyph_reg, glyph_next;
    logic [DECIM_MASK_W-1:0] round_reg, round_next;
    logic                    pend_reg, pend_next;
    logic                    active_reg, active_next;
    logic [BAND_W-1:0]       band_pos_reg, band_pos_next;
    logic [BAND_W-1:0]       bib_reg, bib_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic                    differ_reg, differ_next;
    logic                    prev_valid_reg, prev_valid_next;
    logic [DIV_W-1:0]        rem_reg, rem_next;
    logic [SUM_W-1:0]        quo_reg, quo_next;
    logic [DIV_W-1:0]        div_reg, div_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [BAND_W-1:0]       emit_idx_reg, emit_idx_next;
    logic                    out_valid_reg, out_valid_next;
    logic [BAND_W-1:0]       out_band_reg, out_band_next;
    logic [LEVEL_W-1:0]      out_level_reg, out_level_next;
    logic                    out_last_reg, out_last_next;

    logic [LEVEL_W-1:0]      cur_arr [NUM_BANDS];
    logic [LEVEL_W-1:0]      prev_arr [NUM_BANDS];
    logic                    cur_we;
    logic                    prev_we;

    logic [DIV_W-1:0]        trial;
    logic                    trial_ge;
    logic [DIV_W-1:0]        rem_step;
    logic [SUM_W-1:0]        quo_step;

    logic                    pend_eff;
    logic                    act_tmp;
    logic [BAND_W-1:0]       bpos_tmp;
    logic [BAND_W-1:0]       bib_tmp;
    logic [SUM_W-1:0]        sum_tmp;
    logic [DECIM_MASK_W-1:0] rc_tmp;
    logic [TOTAL_W-1:0]      total;
    logic [PROD_W-1:0]       prod;
    logic [LEVEL_W-1:0]      level;
    logic                    differ_upd;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - BAND_W - LEVEL_W)'(0), out_level_reg, out_band_reg};

    // One step of the restoring divider: shift in the next dividend bit, subtract if it fits.
    assign trial    = {rem_reg[DIV_W-2:0], quo_reg[SUM_W-1]};
    assign trial_ge = (trial >= div_reg);
    assign rem_step = trial_ge ? (trial - div_reg) : trial;
    assign quo_step = {quo_reg[SUM_W-2:0], trial_ge};

    always_comb
    begin
        state_next      = state_reg;
        decimate_next   = decimate_reg;
        glyph_next      = glyph_reg;
        round_next      = round_reg;
        pend_next       = pend_reg;
        active_next     = active_reg;
        band_pos_next   = band_pos_reg;
        bib_next        = bib_reg;
        sum_next        = sum_reg;
        differ_next     = differ_reg;
        prev_valid_next = prev_valid_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        div_next        = div_reg;
        cnt_next        = cnt_reg;
        emit_idx_next   = emit_idx_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_band_next   = out_band_reg;
        out_level_next  = out_level_reg;
        out_last_next   = out_last_reg;
        cur_we          = 1'b0;
        prev_we         = 1'b0;
        pend_eff        = pend_reg;
        act_tmp         = active_reg;
        bpos_tmp        = band_pos_reg;
        bib_tmp         = bib_reg;
        sum_tmp         = sum_reg;
        rc_tmp          = round_reg;
        total           = quo_reg[TOTAL_W-1:0];
        prod            = '0;
        level           = quo_reg[LEVEL_W-1:0];
        differ_upd      = differ_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_DECIMATE: decimate_next = cfg_data[0];
                REG_GLYPH_COUNT:    glyph_next    = cfg_data[GLYPH_W-1:0];
                default:            ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    pend_eff  = pend_reg | s_axis_tuser[1];
                    pend_next = pend_eff;
                    if (s_axis_tuser[0])
                    begin
                        rc_tmp      = decimate_reg ? (round_reg + 1'b1) : '0;
                        round_next  = rc_tmp;
                        act_tmp     = (rc_tmp == '0) || pend_eff;
                        bpos_tmp    = '0;
                        bib_tmp     = '0;
                        sum_tmp     = '0;
                        differ_next = 1'b0;
                    end
                    active_next   = act_tmp;
                    band_pos_next = bpos_tmp;
                    bib_next      = bib_tmp;
                    sum_next      = sum_tmp;
                    if (act_tmp && (bpos_tmp < BAND_W'(NUM_BANDS)))
                    begin
                        sum_tmp  = sum_tmp + SUM_W'(s_axis_tdata[BIN_W-1:0]);
                        bib_tmp  = bib_tmp + 1'b1;
                        sum_next = sum_tmp;
                        bib_next = bib_tmp;
                        if ({1'b0, bib_tmp} >= (WIDTH_W'(FIRST_BAND_WIDTH) + {1'b0, bpos_tmp}))
                        begin
                            sum_next   = '0;
                            bib_next   = '0;
                            rem_next   = '0;
                            quo_next   = sum_tmp;
                            div_next   = band_divisor(bpos_tmp);
                            cnt_next   = '0;
                            state_next = ST_DIV_BAND;
                        end
                    end
                end
            end
            ST_DIV_BAND:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                if (quo_reg > SUM_W'(TOTAL_MAX))
                    total = TOTAL_W'(TOTAL_MAX);
                prod       = PROD_W'(total) * PROD_W'(glyph_reg);
                quo_next   = SUM_W'(prod);
                rem_next   = '0;
                div_next   = DIV_W'(SCALE_DIV);
                cnt_next   = '0;
                state_next = ST_DIV_LEVEL;
            end
            ST_DIV_LEVEL:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                cur_we        = 1'b1;
                differ_upd    = differ_reg || (level != prev_arr[band_pos_reg]);
                differ_next   = differ_upd;
                band_pos_next = band_pos_reg + 1'b1;
                state_next    = ST_IDLE;
                if (band_pos_reg == BAND_W'(NUM_BANDS - 1))
                begin
                    active_next = 1'b0;
                    if (differ_upd || !prev_valid_reg || pend_reg)
                    begin
                        pend_next       = 1'b0;
                        prev_valid_next = 1'b1;
                        emit_idx_next   = '0;
                        state_next      = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_band_next  = emit_idx_reg;
                    out_level_next = cur_arr[emit_idx_reg];
                    out_last_next  = (emit_idx_reg == BAND_W'(NUM_BANDS - 1));
                    prev_we        = 1'b1;
                    if (emit_idx_reg == BAND_W'(NUM_BANDS - 1))
                        state_next = ST_IDLE;
                    else
                        emit_idx_next = emit_idx_reg + 1'b1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            decimate_reg   <= 1'b0;
            glyph_reg      <= GLYPH_W'(GLYPH_RESET);
            round_reg      <= '0;
            pend_reg       <= 1'b0;
            active_reg     <= 1'b0;
            band_pos_reg   <= '0;
            bib_reg        <= '0;
            sum_reg        <= '0;
            differ_reg     <= 1'b0;
            prev_valid_reg <= 1'b0;
            rem_reg        <= '0;
            quo_reg        <= '0;
            div_reg        <= '0;
            cnt_reg        <= '0;
            emit_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_band_reg   <= '0;
            out_level_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            decimate_reg   <= decimate_next;
            glyph_reg      <= glyph_next;
            round_reg      <= round_next;
            pend_reg       <= pend_next;
            active_reg     <= active_next;
            band_pos_reg   <= band_pos_next;
            bib_reg        <= bib_next;
            sum_reg        <= sum_next;
            differ_reg     <= differ_next;
            prev_valid_reg <= prev_valid_next;
            rem_reg        <= rem_next;
            quo_reg        <= quo_next;
            div_reg        <= div_next;
            cnt_reg        <= cnt_next;
            emit_idx_reg   <= emit_idx_next;
            out_valid_reg  <= out_valid_next;
            out_band_reg   <= out_band_next;
            out_level_reg  <= out_level_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cur_we)
            cur_arr[band_pos_reg] <= level;
        if (prev_we)
            prev_arr[emit_idx_reg] <= cur_arr[emit_idx_reg];
    end

    // A new result only appears while the frame is being emitted.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result appeared outside frame emission");

    // The final item of a frame always carries the highest band number.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_band_reg == BAND_W'(NUM_BANDS - 1)))
        else $error("last band flag on wrong band");

    // A pending refresh is only consumed by a frame that goes on to emit.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(pend_reg) |-> (state_reg == ST_EMIT))
        else $error("pending refresh dropped without emission");

    // The band position never runs past the band count.
    assert property (@(posedge clk) disable iff (!rst_n)
        band_pos_reg <= BAND_W'(NUM_BANDS))
        else $error("band position out of range");

    // The divider only runs on a band that exists.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_BAND) |-> (band_pos_reg < BAND_W'(NUM_BANDS)) && active_reg)
        else $error("divider started outside an active band");

endmodule
